>>> design/hbbc_pkg.sv
// Shared types and constants for the hashed block buffer cache.
// Operation and status codes, fixed field widths and the user count limit.
// No dependencies.
package hbbc_pkg;

  localparam int DEV_W     = 8;
  localparam int BLK_W     = 32;
  localparam int USER_W    = 8;

  localparam logic [USER_W-1:0] COUNT_MAX = 8'd255;

  typedef enum logic [1:0] {
    OP_GET     = 2'd0,
    OP_RELEASE = 2'd1,
    OP_PIN     = 2'd2,
    OP_UNPIN   = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_NO_FREE   = 2'd1,
    ST_UNDERFLOW = 2'd2
  } status_t;

endpackage

>>> design/hashed_block_buffer_cache_unit.sv
// Hashed block buffer cache: set-associative tag store with LRU and user counts; uses hbbc_pkg.
// A request passes through REDUCE, ESTIMATE and CORRECT, which reduce the set sum modulo SETS,
// then SCAN, which reads the set through the one memory read port, then a DECIDE step;
// a release that frees a buffer adds a RECENCY pass before the result is offered.
// One request at a time: a new request is accepted only after the previous result is taken.
// Reset (rst, synchronous) clears control state and written flags; unwritten entries read reset.
module hashed_block_buffer_cache_unit
  import hbbc_pkg::*;
#(
  parameter int SETS = 13,
  parameter int WAYS = 4
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [47:0] s_tdata,   // device[7:0], block_number[39:8], slot_way[41:40], zeros
  input  logic [1:0]  s_tuser,   // operation[1:0]
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [7:0]  m_tdata,   // hit[0], fill_needed[1], result_way[3:2], zeros
  output logic [1:0]  m_tuser    // status[1:0]
);

  localparam int WAY_W   = (WAYS > 1) ? $clog2(WAYS) : 1;
  localparam int SET_W   = (SETS > 1) ? $clog2(SETS) : 1;
  localparam int ENTRIES = SETS * WAYS;
  localparam int ADDR_W  = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int CNT_W   = $clog2(WAYS + 1);
  localparam int CMP_W   = (CNT_W > 2) ? CNT_W : 2;

  // Byte weights 256^i mod SETS and the reciprocal that divides the folded sum exactly.
  localparam int SUM_C1  = 256 % SETS;
  localparam int SUM_C2  = 65536 % SETS;
  localparam int SUM_C3  = 16777216 % SETS;
  localparam int RED_K   = 16 + ((SETS > 1) ? $clog2(SETS) : 0);
  localparam int RED_M   = ((1 << RED_K) + SETS - 1) / SETS;
  localparam int MUL_W   = 40;

  typedef struct packed {
    logic [DEV_W-1:0]  dev;
    logic [BLK_W-1:0]  blk;
    logic              valid;
    logic [USER_W-1:0] count;
    logic [WAY_W-1:0]  rank;
  } entry_t;

  typedef enum logic [2:0] {
    IDLE,
    REDUCE,
    ESTIMATE,
    CORRECT,
    SCAN,
    DECIDE,
    RECENCY,
    RESP
  } state_t;

  state_t state;

  // Request registers
  op_t              op;
  logic [DEV_W-1:0] dev;
  logic [BLK_W-1:0] blk;
  logic [1:0]       slot;
  logic [BLK_W-1:0] sum;
  logic [SET_W-1:0] rem;
  logic [15:0]      fold, quot;
  logic [CNT_W-1:0] cnt;

  // Scan results
  logic             m_found, f_found;
  logic [WAY_W-1:0] m_way, f_way;
  entry_t           m_e, f_e, s_e;
  logic [WAY_W-1:0] old_rank;

  // Result registers
  status_t          status;
  logic             hit, fill_needed;
  logic [1:0]       result_way;

  // Memory and its per-entry written flags
  entry_t             mem [ENTRIES];
  logic [ENTRIES-1:0] written;
  entry_t             rd_raw;
  logic               rd_written, rd_pend;
  logic [WAY_W-1:0]   rd_way;
  logic               rd_en, wr_en;
  logic [ADDR_W-1:0]  rd_addr, wr_addr, base_addr;
  entry_t             wr_data, rd_e, rec_data;

  logic [15:0]      fold_next, rem_full;
  logic [MUL_W-1:0] prod;
  logic [WAY_W-1:0] slot_w;
  logic             slot_ok;

  // Decision
  logic             dec_wr;
  logic [WAY_W-1:0] dec_way;
  entry_t           dec_data;
  logic             dec_recency;
  status_t          dec_status;
  logic             dec_hit, dec_fill;
  logic [1:0]       dec_res_way;

  assign s_tready = (state == IDLE) && !rst;
  assign m_tvalid = (state == RESP) && !rst;
  assign m_tdata  = {4'b0, result_way, fill_needed, hit};
  assign m_tuser  = status;

  assign base_addr = ADDR_W'(rem) * ADDR_W'(WAYS);
  assign slot_w    = WAY_W'(slot);
  assign slot_ok   = CMP_W'(slot) < CMP_W'(WAYS);

  // The set sum is folded by bytes into a value below 2^16 with the same remainder; the
  // reciprocal multiplication then gives its exact quotient by SETS.
  assign fold_next = 16'(sum[7:0]) + 16'(sum[15:8]) * 16'(SUM_C1)
                   + 16'(sum[23:16]) * 16'(SUM_C2) + 16'(sum[31:24]) * 16'(SUM_C3);
  assign prod      = MUL_W'(fold) * MUL_W'(RED_M);
  assign rem_full  = fold - quot * 16'(SETS);

  // An entry never written reads as its reset value.
  always_comb begin
    if (rd_written) begin
      rd_e = rd_raw;
    end else begin
      rd_e       = '0;
      rd_e.rank  = rd_way;
    end
  end

  always_comb begin
    rec_data = rd_e;
    if (rd_way == slot_w) begin
      rec_data.rank = WAY_W'(WAYS - 1);
    end else if (rd_e.rank > old_rank) begin
      rec_data.rank = rd_e.rank - 1'b1;
    end
  end

  always_comb begin
    dec_wr      = 1'b0;
    dec_way     = slot_w;
    dec_data    = s_e;
    dec_recency = 1'b0;
    dec_status  = ST_OK;
    dec_hit     = 1'b0;
    dec_fill    = 1'b0;
    dec_res_way = slot;
    if (op == OP_GET) begin
      priority if (m_found) begin
        dec_hit     = 1'b1;
        dec_fill    = ~m_e.valid;
        dec_res_way = 2'(m_way);
        dec_wr      = 1'b1;
        dec_way     = m_way;
        dec_data    = m_e;
        dec_data.valid = 1'b1;
        if (m_e.count != COUNT_MAX) begin
          dec_data.count = m_e.count + 1'b1;
        end
      end else if (f_found) begin
        dec_fill    = 1'b1;
        dec_res_way = 2'(f_way);
        dec_wr      = 1'b1;
        dec_way     = f_way;
        dec_data.dev   = dev;
        dec_data.blk   = blk;
        dec_data.valid = 1'b1;
        dec_data.count = USER_W'(1);
        dec_data.rank  = f_e.rank;
      end else begin
        dec_status  = ST_NO_FREE;
        dec_res_way = 2'd0;
      end
    end else if (slot_ok) begin
      if (op == OP_PIN) begin
        dec_wr = 1'b1;
        if (s_e.count != COUNT_MAX) begin
          dec_data.count = s_e.count + 1'b1;
        end
      end else if (s_e.count == '0) begin
        dec_status = ST_UNDERFLOW;
      end else begin
        dec_wr         = 1'b1;
        dec_data.count = s_e.count - 1'b1;
        // A release that drops the last user makes the way most recent.
        dec_recency    = (op == OP_RELEASE) && (s_e.count == USER_W'(1));
      end
    end
  end

  always_comb begin
    rd_en   = ((state == SCAN) || (state == RECENCY)) && (cnt < CNT_W'(WAYS));
    rd_addr = base_addr + ADDR_W'(cnt);
    wr_en   = 1'b0;
    wr_addr = base_addr + ADDR_W'(dec_way);
    wr_data = dec_data;
    unique case (state)
      DECIDE: begin
        wr_en = dec_wr;
      end
      RECENCY: begin
        wr_en   = rd_pend;
        wr_addr = base_addr + ADDR_W'(rd_way);
        wr_data = rec_data;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_raw <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= IDLE;
      written <= '0;
      rd_pend <= 1'b0;
    end else begin
      rd_pend <= rd_en;
      if (rd_en) begin
        rd_way     <= WAY_W'(cnt);
        rd_written <= written[rd_addr];
      end
      if (wr_en) begin
        written[wr_addr] <= 1'b1;
      end
      unique case (state)
        IDLE: begin
          if (s_tvalid) begin
            op      <= op_t'(s_tuser);
            dev     <= s_tdata[7:0];
            blk     <= s_tdata[39:8];
            slot    <= s_tdata[41:40];
            sum     <= s_tdata[39:8] + BLK_W'(s_tdata[7:0]);
            m_found <= 1'b0;
            f_found <= 1'b0;
            state   <= REDUCE;
          end
        end
        REDUCE: begin
          fold  <= fold_next;
          state <= ESTIMATE;
        end
        ESTIMATE: begin
          quot  <= prod[RED_K +: 16];
          state <= CORRECT;
        end
        CORRECT: begin
          rem   <= rem_full[SET_W-1:0];
          cnt   <= '0;
          state <= SCAN;
        end
        SCAN: begin
          if (rd_pend) begin
            // Latest matching tag wins; least recent free way is the victim.
            if (rd_e.dev == dev && rd_e.blk == blk && (!m_found || rd_e.rank > m_e.rank)) begin
              m_found <= 1'b1;
              m_way   <= rd_way;
              m_e     <= rd_e;
            end
            if (rd_e.count == '0 && (!f_found || rd_e.rank < f_e.rank)) begin
              f_found <= 1'b1;
              f_way   <= rd_way;
              f_e     <= rd_e;
            end
            if (rd_way == slot_w) begin
              s_e <= rd_e;
            end
          end
          if (cnt == CNT_W'(WAYS)) begin
            state <= DECIDE;
          end else begin
            cnt <= cnt + 1'b1;
          end
        end
        DECIDE: begin
          status      <= dec_status;
          hit         <= dec_hit;
          fill_needed <= dec_fill;
          result_way  <= dec_res_way;
          old_rank    <= s_e.rank;
          cnt         <= '0;
          state       <= dec_recency ? RECENCY : RESP;
        end
        RECENCY: begin
          if (cnt == CNT_W'(WAYS)) begin
            state <= RESP;
          end else begin
            cnt <= cnt + 1'b1;
          end
        end
        RESP: begin
          if (m_tready) begin
            state <= IDLE;
          end
        end
        default: begin
          state <= IDLE;
        end
      endcase
    end
  end

endmodule

>>> sim/tb_hashed_block_buffer_cache_unit.sv
`timescale 1ns / 1ps
// Testbench for the hashed block buffer cache: a directed table followed by random requests.
// Results are checked against a behavioural tag store kept in this file, or against the table for typed rows.
// Depends on hbbc_pkg and hashed_block_buffer_cache_unit.
module tb_hashed_block_buffer_cache_unit
  import hbbc_pkg::*;
();

  localparam int SETS           = 13;
  localparam int WAYS           = 4;
  localparam int ENTRIES        = SETS * WAYS;
  localparam int POOL           = 16;
  localparam int RANDOM_ITEMS   = 460;
  localparam int TAIL_CYCLES    = 60;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int SCRIPT_LEN     = 26;

  typedef struct packed {
    status_t    status;
    logic       hit;
    logic       fill;
    logic [1:0] way;
  } reply_t;

  typedef struct {
    op_t         op;
    logic [7:0]  dev;
    logic [31:0] blk;
    logic [1:0]  slot;
    int          reps;
    bit          typed;
    status_t     status;
    logic        hit;
    logic        fill;
    logic [1:0]  way;
  } stim_row_t;

  // Rows with typed set carry a result that can be read straight off the cache rules.
  stim_row_t script [SCRIPT_LEN] = '{
    // Every tag starts as device 0, block 0: all four ways match, the most recent wins.
    '{OP_GET,     8'd0,   32'd0,          2'd0, 1,   1'b1, ST_OK,        1'b1, 1'b1, 2'd3},
    '{OP_GET,     8'd0,   32'd0,          2'd0, 1,   1'b1, ST_OK,        1'b1, 1'b0, 2'd3},
    '{OP_RELEASE, 8'd0,   32'd0,          2'd3, 1,   1'b1, ST_OK,        1'b0, 1'b0, 2'd3},
    '{OP_UNPIN,   8'd0,   32'd0,          2'd0, 1,   1'b1, ST_UNDERFLOW, 1'b0, 1'b0, 2'd0},
    '{OP_RELEASE, 8'd0,   32'd0,          2'd1, 1,   1'b1, ST_UNDERFLOW, 1'b0, 1'b0, 2'd1},
    '{OP_PIN,     8'd0,   32'd0,          2'd2, 1,   1'b1, ST_OK,        1'b0, 1'b0, 2'd2},
    '{OP_GET,     8'd13,  32'd0,          2'd0, 1,   1'b1, ST_OK,        1'b0, 1'b1, 2'd0},
    '{OP_GET,     8'd26,  32'd0,          2'd0, 1,   1'b1, ST_OK,        1'b0, 1'b1, 2'd1},
    '{OP_GET,     8'd39,  32'd0,          2'd0, 1,   1'b1, ST_NO_FREE,   1'b0, 1'b0, 2'd0},
    '{OP_RELEASE, 8'd13,  32'd0,          2'd0, 1,   1'b1, ST_OK,        1'b0, 1'b0, 2'd0},
    '{OP_GET,     8'd39,  32'd0,          2'd0, 1,   1'b1, ST_OK,        1'b0, 1'b1, 2'd0},
    '{OP_GET,     8'd0,   32'd13,         2'd0, 1,   1'b1, ST_NO_FREE,   1'b0, 1'b0, 2'd0},
    // The set sum wraps at 32 bits here.
    '{OP_GET,     8'd255, 32'hFFFF_FFFF,  2'd0, 1,   1'b1, ST_OK,        1'b0, 1'b1, 2'd0},
    '{OP_PIN,     8'd255, 32'hFFFF_FFFF,  2'd0, 260, 1'b0, ST_OK,        1'b0, 1'b0, 2'd0},
    '{OP_GET,     8'd255, 32'hFFFF_FFFF,  2'd0, 1,   1'b1, ST_OK,        1'b1, 1'b0, 2'd0},
    '{OP_RELEASE, 8'd255, 32'hFFFF_FFFF,  2'd0, 255, 1'b0, ST_OK,        1'b0, 1'b0, 2'd0},
    '{OP_RELEASE, 8'd255, 32'hFFFF_FFFF,  2'd0, 1,   1'b1, ST_UNDERFLOW, 1'b0, 1'b0, 2'd0},
    '{OP_UNPIN,   8'd255, 32'hFFFF_FFFF,  2'd3, 1,   1'b1, ST_UNDERFLOW, 1'b0, 1'b0, 2'd3},
    '{OP_PIN,     8'd0,   32'd5,          2'd1, 1,   1'b0, ST_OK,        1'b0, 1'b0, 2'd0},
    '{OP_UNPIN,   8'd0,   32'd5,          2'd1, 1,   1'b1, ST_OK,        1'b0, 1'b0, 2'd1},
    '{OP_GET,     8'hAA,  32'h5555_5555,  2'd0, 1,   1'b0, ST_OK,        1'b0, 1'b0, 2'd0},
    '{OP_GET,     8'h55,  32'hAAAA_AAAA,  2'd0, 1,   1'b0, ST_OK,        1'b0, 1'b0, 2'd0},
    '{OP_RELEASE, 8'd0,   32'd0,          2'd1, 1,   1'b0, ST_OK,        1'b0, 1'b0, 2'd0},
    '{OP_RELEASE, 8'd0,   32'd0,          2'd2, 1,   1'b0, ST_OK,        1'b0, 1'b0, 2'd0},
    '{OP_RELEASE, 8'd0,   32'd0,          2'd3, 1,   1'b0, ST_OK,        1'b0, 1'b0, 2'd0},
    '{OP_RELEASE, 8'd0,   32'd0,          2'd0, 1,   1'b0, ST_OK,        1'b0, 1'b0, 2'd0}
  };

  logic        clk;
  logic        rst;
  logic        s_tvalid;
  logic        s_tready;
  logic [47:0] s_tdata;   // device[7:0], block_number[39:8], slot_way[41:40], zeros
  logic [1:0]  s_tuser;   // operation[1:0]
  logic        m_tvalid;
  logic        m_tready;
  logic [7:0]  m_tdata;   // hit[0], fill_needed[1], result_way[3:2], zeros
  logic [1:0]  m_tuser;   // status[1:0]

  // Behavioural copy of the tag store.
  logic [7:0]  tag_dev_m [ENTRIES];
  logic [31:0] tag_blk_m [ENTRIES];
  bit          valid_m   [ENTRIES];
  logic [7:0]  users_m   [ENTRIES];
  int          rank_m    [ENTRIES];

  reply_t pending_replies [$];
  bit     typed_en;
  reply_t typed_reply;
  bit     steady_phase;
  int     ready_hold;
  int     idle_cycles;
  int     mismatches;

  hashed_block_buffer_cache_unit #(
    .SETS(SETS),
    .WAYS(WAYS)
  ) dut (
    .clk(clk),
    .rst(rst),
    .s_tvalid(s_tvalid),
    .s_tready(s_tready),
    .s_tdata(s_tdata),
    .s_tuser(s_tuser),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .m_tdata(m_tdata),
    .m_tuser(m_tuser)
  );

  always #6 clk = ~clk;

  function automatic int set_of(logic [7:0] dev, logic [31:0] blk);
    logic [31:0] sum;
    sum = blk + 32'(dev);
    return int'(sum % 32'(SETS));
  endfunction

  function automatic reply_t predict_buffer_op(op_t op, logic [7:0] dev, logic [31:0] blk,
                                               logic [1:0] slot);
    reply_t r;
    int     base;
    int     found;
    int     best;
    int     e;
    int     old_rank;
    r     = '{ST_OK, 1'b0, 1'b0, 2'd0};
    base  = set_of(dev, blk) * WAYS;
    found = -1;
    if (op == OP_GET) begin
      best = -1;
      for (int w = 0; w < WAYS; w++) begin
        if (tag_dev_m[base+w] == dev && tag_blk_m[base+w] == blk && rank_m[base+w] > best) begin
          best  = rank_m[base+w];
          found = w;
        end
      end
      if (found >= 0) begin
        r.hit = 1'b1;
        if (users_m[base+found] < COUNT_MAX) users_m[base+found]++;
      end else begin
        best = WAYS;
        for (int w = 0; w < WAYS; w++) begin
          if (users_m[base+w] == 0 && rank_m[base+w] < best) begin
            best  = rank_m[base+w];
            found = w;
          end
        end
        if (found >= 0) begin
          tag_dev_m[base+found] = dev;
          tag_blk_m[base+found] = blk;
          valid_m[base+found]   = 1'b0;
          users_m[base+found]   = 8'd1;
        end else begin
          r.status = ST_NO_FREE;
        end
      end
      if (found >= 0) begin
        r.way  = 2'(found);
        r.fill = !valid_m[base+found];
        valid_m[base+found] = 1'b1;
      end
    end else begin
      r.way = slot;
      if (int'(slot) < WAYS) begin
        e = base + int'(slot);
        if (op == OP_PIN) begin
          if (users_m[e] < COUNT_MAX) users_m[e]++;
        end else if (users_m[e] == 0) begin
          r.status = ST_UNDERFLOW;
        end else begin
          users_m[e]--;
          // A freed buffer moves to the most recent end; ranks above it close the gap.
          if (op == OP_RELEASE && users_m[e] == 0) begin
            old_rank = rank_m[e];
            for (int w = 0; w < WAYS; w++) begin
              if (rank_m[base+w] > old_rank) rank_m[base+w]--;
            end
            rank_m[e] = WAYS - 1;
          end
        end
      end
    end
    return r;
  endfunction

  task automatic issue_request(input op_t op, input logic [7:0] dev, input logic [31:0] blk,
                               input logic [1:0] slot, input bit typed, input reply_t want);
    int gap;
    gap = steady_phase ? 0 : $urandom_range(0, 5);
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    s_tvalid    <= 1'b1;
    s_tuser     <= op;
    s_tdata     <= {6'd0, slot, blk, dev};
    typed_en    <= typed;
    typed_reply <= want;
    do @(posedge clk); while (!s_tready);
    @(negedge clk);
  endtask

  // The receiver holds off for a drawn number of cycles before each result.
  always @(negedge clk) begin
    if (ready_hold > 0) begin
      m_tready <= 1'b0;
      ready_hold--;
    end else begin
      m_tready <= 1'b1;
    end
  end

  // Results are checked before the request of the same edge is predicted.
  always @(posedge clk) begin
    reply_t want;
    reply_t got;
    if (!rst) begin
      if (m_tvalid && m_tready) begin
        got = '{status_t'(m_tuser), m_tdata[0], m_tdata[1], m_tdata[3:2]};
        ready_hold = steady_phase ? 0 : $urandom_range(0, 5);
        if (pending_replies.size() == 0) begin
          $error("result with nothing outstanding: status %0d hit %0d fill %0d way %0d",
                 got.status, got.hit, got.fill, got.way);
          mismatches++;
        end else begin
          want = pending_replies.pop_front();
          if (got.status !== want.status) begin
            $error("status: expected %0d, actual %0d", want.status, got.status);
            mismatches++;
          end
          if (got.hit !== want.hit) begin
            $error("hit: expected %0d, actual %0d", want.hit, got.hit);
            mismatches++;
          end
          if (got.fill !== want.fill) begin
            $error("fill_needed: expected %0d, actual %0d", want.fill, got.fill);
            mismatches++;
          end
          if (got.way !== want.way) begin
            $error("result_way: expected %0d, actual %0d", want.way, got.way);
            mismatches++;
          end
        end
      end
      if (s_tvalid && s_tready) begin
        want = predict_buffer_op(op_t'(s_tuser), s_tdata[7:0], s_tdata[39:8], s_tdata[41:40]);
        pending_replies.push_back(typed_en ? typed_reply : want);
      end
      if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
        idle_cycles = 0;
      end else begin
        idle_cycles++;
      end
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("[FAIL] regression broken");
        $finish;
      end
    end
  end

  initial begin
    logic [7:0]  pool_dev [POOL];
    logic [31:0] pool_blk [POOL];
    int          busy_ways [WAYS];
    int          busy_n;
    int          pick;
    int          base;
    op_t         op;
    logic [7:0]  dev;
    logic [31:0] blk;
    logic [1:0]  slot;
    clk          = 1'b0;
    rst          = 1'b1;
    s_tvalid     = 1'b0;
    s_tdata      = '0;
    s_tuser      = OP_GET;
    m_tready     = 1'b0;
    typed_en     = 1'b0;
    typed_reply  = '{ST_OK, 1'b0, 1'b0, 2'd0};
    steady_phase = 1'b0;
    ready_hold   = 0;
    idle_cycles  = 0;
    mismatches   = 0;
    for (int i = 0; i < ENTRIES; i++) begin
      tag_dev_m[i] = '0;
      tag_blk_m[i] = '0;
      valid_m[i]   = 1'b0;
      users_m[i]   = '0;
      rank_m[i]    = i % WAYS;
    end
    // A small pool of blocks keeps hits and full sets frequent.
    for (int i = 0; i < POOL; i++) begin
      pool_dev[i] = 8'($urandom_range(0, 255));
      pool_blk[i] = $urandom;
    end
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    foreach (script[i]) begin
      for (int n = 0; n < script[i].reps; n++) begin
        issue_request(script[i].op, script[i].dev, script[i].blk, script[i].slot, script[i].typed,
                      '{script[i].status, script[i].hit, script[i].fill, script[i].way});
      end
    end

    for (int i = 0; i < RANDOM_ITEMS; i++) begin
      if (i % 50 == 0) steady_phase = ($urandom_range(0, 3) == 0);
      if ($urandom_range(0, 9) < 7) begin
        pick = $urandom_range(0, POOL - 1);
        dev  = pool_dev[pick];
        blk  = pool_blk[pick];
      end else begin
        dev = 8'($urandom_range(0, 255));
        blk = $urandom;
      end
      pick = $urandom_range(0, 99);
      if (pick < 35) op = OP_GET;
      else if (pick < 70) op = OP_RELEASE;
      else if (pick < 80) op = OP_PIN;
      else op = OP_UNPIN;
      slot = 2'($urandom_range(0, 3));
      // Most drops go to a way that actually holds users, so buffers do get freed.
      if ((op == OP_RELEASE || op == OP_UNPIN) && $urandom_range(0, 9) < 7) begin
        base   = set_of(dev, blk) * WAYS;
        busy_n = 0;
        for (int w = 0; w < WAYS; w++) begin
          if (users_m[base+w] != 0) begin
            busy_ways[busy_n] = w;
            busy_n++;
          end
        end
        if (busy_n > 0) slot = 2'(busy_ways[$urandom_range(0, busy_n - 1)]);
      end
      issue_request(op, dev, blk, slot, 1'b0, '{ST_OK, 1'b0, 1'b0, 2'd0});
    end
    s_tvalid <= 1'b0;

    while (pending_replies.size() > 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);
    if (mismatches == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
